@@ hdl/mtea_pkg.sv @@
// Package for the moments-to-ellipse-axes block: widths, pipeline depths and
// the CORDIC arctangent table. Depends on nothing; the sqrt, CORDIC and top modules import it.
package mtea_pkg;

   localparam int RadW      = 66;
   localparam int RootW     = 33;
   localparam int RemW      = 35;
   localparam int SqrtSteps = 33;

   localparam int CordW     = 60;
   localparam int CordSteps = 30;

   // Stage 1 takes the item, stage Latency drives the result channel.
   localparam int Latency   = 71;
   localparam int SumDelay  = 33;
   localparam int FlagDelay = 33;
   localparam int ZeroDelay = 31;
   localparam int AngDelay  = 37;

   localparam logic [23:0] AxisMax = 24'hFFFFFF;

   localparam logic [31:0] AtanTab [CordSteps] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
   };

endpackage

@@ hdl/mtea_if.sv @@
// Valid/ready channel interfaces for the moment items and the axis items.
// Depends on nothing.
interface mtea_req_if;
   logic               valid;
   logic               ready;
   logic        [31:0] moment_xx;
   logic        [31:0] moment_yy;
   logic signed [31:0] moment_xy;

   modport source (output valid, moment_xx, moment_yy, moment_xy, input ready);
   modport sink   (input valid, moment_xx, moment_yy, moment_xy, output ready);
endinterface

interface mtea_rsp_if;
   logic               valid;
   logic               ready;
   logic        [23:0] major_axis;
   logic        [23:0] minor_axis;
   logic signed [15:0] position_angle;
   logic               not_positive;

   modport source (output valid, major_axis, minor_axis, position_angle, not_positive,
                   input ready);
   modport sink   (input valid, major_axis, minor_axis, position_angle, not_positive,
                   output ready);
endinterface

@@ hdl/mtea_sqrt.sv @@
// Pipelined floor square root of a 66 bit radicand, one root bit per stage.
// Depends on mtea_pkg.
module mtea_sqrt
   import mtea_pkg::*;
(
   input  logic             clock,
   input  logic             en,
   input  logic [RadW-1:0]  rad_i,
   output logic [RootW-1:0] root_o
);

   logic [RadW-1:0]  rad_ff  [SqrtSteps];
   logic [RemW-1:0]  rem_ff  [SqrtSteps];
   logic [RootW-1:0] root_ff [SqrtSteps];
   logic [RadW-1:0]  rad_in  [SqrtSteps];
   logic [RemW-1:0]  rem_in  [SqrtSteps];
   logic [RootW-1:0] root_in [SqrtSteps];

   always_comb begin
      logic [RadW-1:0]  cur_rad;
      logic [RemW-1:0]  cur_rem;
      logic [RootW-1:0] cur_root;
      logic [RemW+1:0]  shifted;
      logic [RemW+1:0]  trial;
      for (int j = 0; j < SqrtSteps; j++) begin
         if (j == 0) begin
            cur_rad  = rad_i;
            cur_rem  = '0;
            cur_root = '0;
         end else begin
            cur_rad  = rad_ff[j-1];
            cur_rem  = rem_ff[j-1];
            cur_root = root_ff[j-1];
         end
         shifted   = {cur_rem, cur_rad[RadW-1 -: 2]};
         trial     = {2'b00, cur_root, 2'b01};
         rad_in[j] = cur_rad << 2;
         if (shifted >= trial) begin
            rem_in[j]  = RemW'(shifted - trial);
            root_in[j] = {cur_root[RootW-2:0], 1'b1};
         end else begin
            rem_in[j]  = RemW'(shifted);
            root_in[j] = {cur_root[RootW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < SqrtSteps; j++) begin
            rad_ff[j]  <= rad_in[j];
            rem_ff[j]  <= rem_in[j];
            root_ff[j] <= root_in[j];
         end
      end
   end

   assign root_o = root_ff[SqrtSteps-1];

endmodule

@@ hdl/mtea_cordic.sv @@
// Pipelined vectoring CORDIC: 32 bit binary angle of (diff, 2*xy).
// One pre-rotation stage, then one micro-rotation per stage. Depends on mtea_pkg.
module mtea_cordic
   import mtea_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic signed [32:0] diff_i,
   input  logic signed [31:0] xy_i,
   output logic        [31:0] ang_o
);

   logic signed [CordW-1:0] x0_ff, y0_ff;
   logic        [31:0]      a0_ff;
   logic signed [CordW-1:0] x_ff [CordSteps];
   logic signed [CordW-1:0] y_ff [CordSteps];
   logic        [31:0]      a_ff [CordSteps];
   logic signed [CordW-1:0] x_in [CordSteps];
   logic signed [CordW-1:0] y_in [CordSteps];
   logic        [31:0]      a_in [CordSteps];
   logic signed [CordW-1:0] xs, ys;

   // Scale both coordinates by 2^24; y also carries the factor of two.
   assign xs = CordW'(diff_i) <<< 24;
   assign ys = CordW'(xy_i) <<< 25;

   always_comb begin
      logic signed [CordW-1:0] cx, cy;
      logic        [31:0]      ca;
      for (int i = 0; i < CordSteps; i++) begin
         if (i == 0) begin
            cx = x0_ff; cy = y0_ff; ca = a0_ff;
         end else begin
            cx = x_ff[i-1]; cy = y_ff[i-1]; ca = a_ff[i-1];
         end
         if (cy > 0) begin
            x_in[i] = cx + (cy >>> i);
            y_in[i] = cy - (cx >>> i);
            a_in[i] = ca + AtanTab[i];
         end else begin
            x_in[i] = cx - (cy >>> i);
            y_in[i] = cy + (cx >>> i);
            a_in[i] = ca - AtanTab[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (xs < 0) begin
            x0_ff <= -xs;
            y0_ff <= -ys;
            a0_ff <= 32'h80000000;
         end else begin
            x0_ff <= xs;
            y0_ff <= ys;
            a0_ff <= '0;
         end
         for (int i = 0; i < CordSteps; i++) begin
            x_ff[i] <= x_in[i];
            y_ff[i] <= y_in[i];
            a_ff[i] <= a_in[i];
         end
      end
   end

   assign ang_o = a_ff[CordSteps-1];

endmodule

@@ hdl/moments_to_ellipse_axes_top.sv @@
// Throughput: one item per cycle; the whole pipeline advances together and
// holds while the output register is full and not taken.
// Reset (synchronous, active high) clears only the valid bits; data registers
// keep whatever they hold. Depends on mtea_pkg, mtea_if, mtea_sqrt, mtea_cordic.
module moments_to_ellipse_axes_top
   import mtea_pkg::*;
(
   input logic clock,
   input logic reset,
   mtea_req_if.sink   req_ch,
   mtea_rsp_if.source rsp_ch
);

   // One valid bit per stage; index 0 is the stage that registers the item.
   logic [Latency-1:0] vld_ff;
   logic               adv;

   // The pipeline moves whenever the output register is empty or being taken.
   // An item may enter in that same cycle, so items flow back to back.
   // No item is taken while reset is held.
   assign adv          = !vld_ff[Latency-1] || rsp_ch.ready;
   assign req_ch.ready = adv && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[Latency-2:0], req_ch.valid};
      end
   end

   // Stage 1: sum, difference and magnitudes.
   logic        [31:0] xx_ff, yy_ff;
   logic        [32:0] sum_a_ff;
   logic signed [32:0] diff_a_ff;
   logic signed [31:0] xy_a_ff;
   logic        [31:0] dabs_ff, zabs_ff;
   logic               zero_a_ff;
   logic signed [32:0] diff_in;
   logic signed [32:0] xy_wide;

   assign diff_in = $signed({1'b0, req_ch.moment_xx}) - $signed({1'b0, req_ch.moment_yy});
   assign xy_wide = 33'(req_ch.moment_xy);

   always_ff @(posedge clock) begin
      if (adv) begin
         xx_ff     <= req_ch.moment_xx;
         yy_ff     <= req_ch.moment_yy;
         sum_a_ff  <= {1'b0, req_ch.moment_xx} + {1'b0, req_ch.moment_yy};
         diff_a_ff <= diff_in;
         xy_a_ff   <= req_ch.moment_xy;
         dabs_ff   <= diff_in[32] ? 32'(-diff_in) : diff_in[31:0];
         zabs_ff   <= xy_wide[32] ? 32'(-xy_wide) : xy_wide[31:0];
         zero_a_ff <= (diff_in == '0) && (req_ch.moment_xy == '0);
      end
   end

   // Stage 2: the three 32 by 32 products.
   logic [63:0] d2_ff, z2_ff, prod_ff;
   logic [32:0] sum_b_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         d2_ff    <= 64'(dabs_ff) * 64'(dabs_ff);
         z2_ff    <= 64'(zabs_ff) * 64'(zabs_ff);
         prod_ff  <= 64'(xx_ff) * 64'(yy_ff);
         sum_b_ff <= sum_a_ff;
      end
   end

   // Stage 3: t squared in unsigned Q66.0 and the semidefinite test.
   logic [RadW-1:0] tsq_ff;
   logic [32:0]     sum_c_ff;
   logic            flag_c_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         tsq_ff    <= {2'b00, d2_ff} + {z2_ff, 2'b00};
         sum_c_ff  <= sum_b_ff;
         flag_c_ff <= prod_ff < z2_ff;
      end
   end

   // Stages 4 to 36: t = floor sqrt of t squared.
   logic [RootW-1:0] t_root;

   mtea_sqrt u_sqrt_t (
      .clock  (clock),
      .en     (adv),
      .rad_i  (tsq_ff),
      .root_o (t_root)
   );

   // The sum and the flag wait alongside the root.
   logic [32:0] sum_dl_ff  [SumDelay];
   logic        flag_dl_ff [FlagDelay];

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_dl_ff[0]  <= sum_c_ff;
         flag_dl_ff[0] <= flag_c_ff;
         for (int i = 1; i < SumDelay; i++) begin
            sum_dl_ff[i] <= sum_dl_ff[i-1];
         end
         for (int i = 1; i < FlagDelay; i++) begin
            flag_dl_ff[i] <= flag_dl_ff[i-1];
         end
      end
   end

   // Stage 37: radicands of the two axes, each scaled by 2^15 so the axis roots land in Q16.8.
   // The minor radicand is zero when the moments are not semidefinite or t
   // exceeds the sum, which makes the minor axis zero.
   logic [RadW-1:0] rad_a_ff, rad_b_ff;
   logic            flag_d_ff;
   logic [32:0]     sum_t;
   logic [33:0]     sum_plus;
   logic [32:0]     sum_minus;
   logic            flag_t;

   assign sum_t     = sum_dl_ff[SumDelay-1];
   assign flag_t    = flag_dl_ff[FlagDelay-1];
   assign sum_plus  = {1'b0, sum_t} + {1'b0, t_root};
   assign sum_minus = sum_t - t_root;

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_a_ff  <= {17'b0, sum_plus, 15'b0};
         rad_b_ff  <= (flag_t || (t_root > sum_t)) ? '0 : {18'b0, sum_minus, 15'b0};
         flag_d_ff <= flag_t;
      end
   end

   // Stages 38 to 70: the two axis roots side by side.
   logic [RootW-1:0] a_root, b_root;

   mtea_sqrt u_sqrt_a (
      .clock  (clock),
      .en     (adv),
      .rad_i  (rad_a_ff),
      .root_o (a_root)
   );

   mtea_sqrt u_sqrt_b (
      .clock  (clock),
      .en     (adv),
      .rad_i  (rad_b_ff),
      .root_o (b_root)
   );

   logic flag_e_ff [FlagDelay];

   always_ff @(posedge clock) begin
      if (adv) begin
         flag_e_ff[0] <= flag_d_ff;
         for (int i = 1; i < FlagDelay; i++) begin
            flag_e_ff[i] <= flag_e_ff[i-1];
         end
      end
   end

   // Angle path: the CORDIC runs from stage 2 to 32, next to the t root.
   logic [31:0] ang;
   logic        zero_dl_ff [ZeroDelay];

   mtea_cordic u_cordic (
      .clock  (clock),
      .en     (adv),
      .diff_i (diff_a_ff),
      .xy_i   (xy_a_ff),
      .ang_o  (ang)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         zero_dl_ff[0] <= zero_a_ff;
         for (int i = 1; i < ZeroDelay; i++) begin
            zero_dl_ff[i] <= zero_dl_ff[i-1];
         end
      end
   end

   // Stage 33: halve the angle by keeping the rounded upper half of the
   // binary angle; a zero vector gives angle zero. Then the angle waits
   // until stage 70.
   logic [31:0] ang_round;
   logic [15:0] pa_dl_ff [AngDelay + 1];

   assign ang_round = ang + 32'h00008000;

   always_ff @(posedge clock) begin
      if (adv) begin
         pa_dl_ff[0] <= zero_dl_ff[ZeroDelay-1] ? 16'h0000 : ang_round[31:16];
         for (int i = 1; i <= AngDelay; i++) begin
            pa_dl_ff[i] <= pa_dl_ff[i-1];
         end
      end
   end

   // Stage 71: saturate the axes and present the item.
   logic [23:0]        major_ff, minor_ff;
   logic signed [15:0] pa_ff;
   logic               np_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         major_ff <= (a_root[RootW-1:24] != '0) ? AxisMax : a_root[23:0];
         minor_ff <= (b_root[RootW-1:24] != '0) ? AxisMax : b_root[23:0];
         pa_ff    <= $signed(pa_dl_ff[AngDelay]);
         np_ff    <= flag_e_ff[FlagDelay-1];
      end
   end

   assign rsp_ch.valid          = vld_ff[Latency-1];
   assign rsp_ch.major_axis     = major_ff;
   assign rsp_ch.minor_axis     = minor_ff;
   assign rsp_ch.position_angle = pa_ff;
   assign rsp_ch.not_positive   = np_ff;

endmodule
